### src/bsft_pkg.sv
package bsft_pkg;

	// Fixed-point format
	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	// Field widths
	localparam int COORD_W = 24;
	localparam int PH_W    = 17;
	localparam int SH_W    = 23;
	localparam int POS_W   = 25;
	localparam int VEL_W   = 26;

	// Internal widths: deltas and bases, blend and slope coefficients,
	// coefficient-by-delta products and the final sums
	localparam int DW    = 26;
	localparam int CW    = 18;
	localparam int MUL_W = CW + 1 + DW;
	localparam int SUM_W = MUL_W + 1;

	localparam logic signed [SUM_W-1:0] HALF_S  = SUM_W'(HALF);
	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(16777215);
	localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(16777216);
	localparam logic signed [SUM_W-1:0] VEL_MAX = SUM_W'(33554431);
	localparam logic signed [SUM_W-1:0] VEL_MIN = -SUM_W'(33554432);

	// Blend value and slope for one phase
	typedef struct packed {
		logic [CW-1:0] a;
		logic [CW-1:0] s;
	} coef_t;

	// Per-item distances and base points carried down the pipeline
	typedef struct packed {
		logic [DW-1:0] dx;
		logic [DW-1:0] dy;
		logic [DW-1:0] dz;
		logic [DW-1:0] bx;
		logic [DW-1:0] by;
		logic [DW-1:0] bz;
	} geom_t;

	// Round half up, then drop the fraction bits
	function automatic logic signed [SUM_W-1:0] rnd_s(input logic signed [MUL_W-1:0] m);
		logic signed [SUM_W-1:0] y;
		y = $signed({m[MUL_W-1], m}) + HALF_S;
		return y >>> FRAC_BITS;
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		priority if (v < POS_MIN) c = POS_MIN;
		else if (v > POS_MAX) c = POS_MAX;
		else c = v;
		return c[POS_W-1:0];
	endfunction

	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		priority if (v < VEL_MIN) c = VEL_MIN;
		else if (v > VEL_MAX) c = VEL_MAX;
		else c = v;
		return c[VEL_W-1:0];
	endfunction

endpackage

### src/bsft_blend.sv
// Blend 3t^2 - 2t^3 and slope 6t(1 - t) of a phase, four register stages.
module bsft_blend import bsft_pkg::*; (
	input  logic            clk,
	input  logic [PH_W-1:0] t,
	output coef_t           coef
);

	localparam int PP_W = 2 * PH_W;
	localparam int QW   = PP_W + 2;
	localparam int PR_W = PH_W + CW;

	logic [PH_W-1:0] omt;
	logic [PH_W-1:0] t_s2;
	logic [PP_W-1:0] pp_s2;
	logic [PP_W-1:0] qq_s2;
	logic [PP_W:0]   pp_r;
	logic [QW-1:0]   six_q;
	logic [QW-1:0]   s_r;
	logic [PH_W-1:0] t2_s3;
	logic [CW-1:0]   fac_s3;
	logic [CW-1:0]   s_s3;
	logic [PR_W-1:0] prod_s4;
	logic [CW-1:0]   s_s4;
	logic [PR_W:0]   a_r;
	coef_t           coef_s5;

	assign omt = PH_W'(ONE) - t;

	// t^2 rounded, and 6 q rounded as shift-and-add
	assign pp_r  = {1'b0, pp_s2} + (PP_W + 1)'(HALF);
	assign six_q = {qq_s2, 2'b00} + {1'b0, qq_s2, 1'b0};
	assign s_r   = six_q + QW'(HALF);
	assign a_r   = {1'b0, prod_s4} + (PR_W + 1)'(HALF);

	always_ff @(posedge clk) begin
		t_s2    <= t;
		pp_s2   <= PP_W'(t) * PP_W'(t);
		qq_s2   <= PP_W'(t) * PP_W'(omt);

		t2_s3   <= pp_r[FRAC_BITS +: PH_W];
		fac_s3  <= CW'(3 * ONE) - {t_s2, 1'b0};
		s_s3    <= s_r[FRAC_BITS +: CW];

		prod_s4 <= PR_W'(t2_s3) * PR_W'(fac_s3);
		s_s4    <= s_s3;

		coef_s5.a <= a_r[FRAC_BITS +: CW];
		coef_s5.s <= s_s4;
	end

	assign coef = coef_s5;

endmodule

### src/bezier_swing_foot_trajectory_top.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------------
// command   | start_x/y/z, end_x/y/z, phase                | taken when start & !busy
// result    | pos_x/y/z, vel_x/y/z                         | done strobe, one cycle, no stall
// config    | cfg_wdata (swing_height)                     | written when cfg_we
//
// Seven register stages, s1 to s7: an accepted word comes out with done from the stage-7 registers.
// A new word is taken every cycle; busy stays low, since nothing in the pipe ever waits.
// The receiver cannot stall, so results leave on fixed timing and valid bits just shift.
// arst_n clears the valid bits and swing_height; payload registers carry no reset.
// Latency is set by the chain of multiplies: t*t, t2*(3-2t), then coef*delta; every
// stage is registered, so the rate is one word per cycle.
module bezier_swing_foot_trajectory_top import bsft_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] start_z,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic signed [COORD_W-1:0] end_z,
	input  logic        [PH_W-1:0]    phase,
	input  logic                      cfg_we,
	input  logic        [SH_W-1:0]    cfg_wdata,
	output logic                      done,
	output logic signed [POS_W-1:0]   pos_x,
	output logic signed [POS_W-1:0]   pos_y,
	output logic signed [POS_W-1:0]   pos_z,
	output logic signed [VEL_W-1:0]   vel_x,
	output logic signed [VEL_W-1:0]   vel_y,
	output logic signed [VEL_W-1:0]   vel_z
);

	logic [SH_W-1:0] sh_q;

	// Stage 0 (combinational, ahead of the first register)
	logic                   accept;
	logic [PH_W-1:0]        p_c;
	logic [PH_W:0]          p2_c;
	logic                   rise_c;
	logic [PH_W-1:0]        tz_c;
	logic signed [DW-1:0]   sx_e, sy_e, sz_e, ex_e, ey_e, ez_e;
	logic signed [DW-1:0]   zmid_c;
	geom_t                  geom_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [PH_W-1:0] p_s1;
	logic [PH_W-1:0] tz_s1;
	geom_t           geom_s1, geom_s2, geom_s3, geom_s4, geom_s5;
	coef_t           cxy_s5;
	coef_t           cz_s5;

	logic signed [MUL_W-1:0] m_px_s6, m_py_s6, m_pz_s6, m_vx_s6, m_vy_s6, m_vz_s6;
	logic signed [DW-1:0]    bx_s6, by_s6, bz_s6;

	logic signed [SUM_W-1:0] px_c, py_c, pz_c, vx_c, vy_c, vz_c;

	logic [POS_W-1:0] pos_x_s7, pos_y_s7, pos_z_s7;
	logic [VEL_W-1:0] vel_x_s7, vel_y_s7, vel_z_s7;

	// Nothing ever backs up, so a word is taken on every start
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Configuration: the user must write it only while the pipe is empty; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
		end else if (cfg_we) begin
			sh_q <= cfg_wdata;
		end
	end

	// Clamp phase to one; split z at one half, which belongs to the rising half
	always_comb begin
		p_c    = (phase > PH_W'(ONE)) ? PH_W'(ONE) : phase;
		p2_c   = {p_c, 1'b0};
		rise_c = (p_c <= PH_W'(ONE / 2));
		tz_c   = rise_c ? p2_c[PH_W-1:0] : PH_W'(p2_c - (PH_W + 1)'(ONE));
	end

	// Distances and bases: x and y run start to end, z runs to or from the lift point
	always_comb begin
		sx_e   = $signed({{(DW - COORD_W){start_x[COORD_W-1]}}, start_x});
		sy_e   = $signed({{(DW - COORD_W){start_y[COORD_W-1]}}, start_y});
		sz_e   = $signed({{(DW - COORD_W){start_z[COORD_W-1]}}, start_z});
		ex_e   = $signed({{(DW - COORD_W){end_x[COORD_W-1]}}, end_x});
		ey_e   = $signed({{(DW - COORD_W){end_y[COORD_W-1]}}, end_y});
		ez_e   = $signed({{(DW - COORD_W){end_z[COORD_W-1]}}, end_z});
		zmid_c = ez_e + $signed({{(DW - SH_W){1'b0}}, sh_q});

		geom_c.dx = ex_e - sx_e;
		geom_c.dy = ey_e - sy_e;
		geom_c.bx = sx_e;
		geom_c.by = sy_e;
		if (rise_c) begin
			geom_c.dz = zmid_c - sz_e;
			geom_c.bz = sz_e;
		end else begin
			geom_c.dz = ez_e - zmid_c;
			geom_c.bz = zmid_c;
		end
	end

	// Valid bits: advance one stage every cycle, the receiver never holds off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1 capture, then carry the geometry alongside the blend units
	always_ff @(posedge clk) begin
		p_s1    <= p_c;
		tz_s1   <= tz_c;
		geom_s1 <= geom_c;
		geom_s2 <= geom_s1;
		geom_s3 <= geom_s2;
		geom_s4 <= geom_s3;
		geom_s5 <= geom_s4;
	end

	// Stages 2..5: blend and slope for the x/y phase and the local z phase
	bsft_blend u_blend_xy (
		.clk  (clk),
		.t    (p_s1),
		.coef (cxy_s5)
	);

	bsft_blend u_blend_z (
		.clk  (clk),
		.t    (tz_s1),
		.coef (cz_s5)
	);

	// Stage 6: scale each distance by its blend value and by its slope
	always_ff @(posedge clk) begin
		m_px_s6 <= MUL_W'($signed({1'b0, cxy_s5.a})) * MUL_W'($signed(geom_s5.dx));
		m_py_s6 <= MUL_W'($signed({1'b0, cxy_s5.a})) * MUL_W'($signed(geom_s5.dy));
		m_pz_s6 <= MUL_W'($signed({1'b0, cz_s5.a}))  * MUL_W'($signed(geom_s5.dz));
		m_vx_s6 <= MUL_W'($signed({1'b0, cxy_s5.s})) * MUL_W'($signed(geom_s5.dx));
		m_vy_s6 <= MUL_W'($signed({1'b0, cxy_s5.s})) * MUL_W'($signed(geom_s5.dy));
		m_vz_s6 <= MUL_W'($signed({1'b0, cz_s5.s}))  * MUL_W'($signed(geom_s5.dz));
		bx_s6   <= $signed(geom_s5.bx);
		by_s6   <= $signed(geom_s5.by);
		bz_s6   <= $signed(geom_s5.bz);
	end

	// Stage 7: round, add the base point to the positions, saturate to the port ranges
	always_comb begin
		px_c = rnd_s(m_px_s6) + $signed({{(SUM_W - DW){bx_s6[DW-1]}}, bx_s6});
		py_c = rnd_s(m_py_s6) + $signed({{(SUM_W - DW){by_s6[DW-1]}}, by_s6});
		pz_c = rnd_s(m_pz_s6) + $signed({{(SUM_W - DW){bz_s6[DW-1]}}, bz_s6});
		vx_c = rnd_s(m_vx_s6);
		vy_c = rnd_s(m_vy_s6);
		vz_c = rnd_s(m_vz_s6);
	end

	always_ff @(posedge clk) begin
		pos_x_s7 <= sat_pos(px_c);
		pos_y_s7 <= sat_pos(py_c);
		pos_z_s7 <= sat_pos(pz_c);
		vel_x_s7 <= sat_vel(vx_c);
		vel_y_s7 <= sat_vel(vy_c);
		vel_z_s7 <= sat_vel(vz_c);
	end

	assign done  = vld_s7;
	assign pos_x = $signed(pos_x_s7);
	assign pos_y = $signed(pos_y_s7);
	assign pos_z = $signed(pos_z_s7);
	assign vel_x = $signed(vel_x_s7);
	assign vel_y = $signed(vel_y_s7);
	assign vel_z = $signed(vel_z_s7);

endmodule

### src/bsft_checker.sv
module bsft_checker import bsft_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [COORD_W-1:0] start_x,
	input logic signed [COORD_W-1:0] end_x,
	input logic signed [COORD_W-1:0] end_z,
	input logic        [PH_W-1:0]    phase,
	input logic signed [POS_W-1:0]   pos_x,
	input logic signed [POS_W-1:0]   pos_z,
	input logic signed [VEL_W-1:0]   vel_x,
	input logic signed [VEL_W-1:0]   vel_z
);

	// Every accepted word comes out with done
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("accepted word did not come out after seven cycles");

	// No result without a matching accepted word
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result strobe without a matching accepted word");

	// Zero phase: the foot sits at the start point, x not moving
	a_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && phase == '0) |->
		##7 (pos_x == $past(start_x, 7) && vel_x == '0))
		else $error("zero phase did not return the start point");

	// Full phase or beyond: the foot lands on the end point at rest
	a_phase_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && phase >= PH_W'(ONE)) |->
		##7 (pos_x == $past(end_x, 7) && pos_z == $past(end_z, 7)
			&& vel_x == '0 && vel_z == '0))
		else $error("full phase did not land on the end point");

endmodule

bind bezier_swing_foot_trajectory_top bsft_checker u_bsft_checker (.*);
